// ----- hdl/sqm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square wave frequency meter package
// Field widths, register map and display constants shared by the meter.
// ----------------------------------------------------------------------------
package sqm_pkg;

  // Configuration register
  localparam int unsigned TPS_W        = 20;
  localparam int unsigned TPS_RESET    = 1000000;
  localparam int unsigned APB_ADDR_W   = 3;
  localparam int unsigned APB_DATA_W   = 32;
  localparam logic        REG_TPS      = 1'b0;

  // Result fields
  localparam int unsigned PERIOD_W     = 17;
  localparam int unsigned FREQ_W       = 19;
  localparam int unsigned NUM_DIGITS   = 5;
  localparam int unsigned DIGIT_W      = 4;
  localparam int unsigned BCD_W        = NUM_DIGITS * DIGIT_W;
  localparam int unsigned DISP_W       = 17;
  localparam int unsigned PERIOD_MAX   = 131071;
  localparam int unsigned DISPLAY_MAX  = 99999;

  // Stream widths
  localparam int unsigned IN_TDATA_W   = 8;
  localparam int unsigned OUT_TDATA_W  = 80;

  // Step counters of the serial units
  localparam int unsigned DIV_CNT_W    = $clog2(TPS_W);
  localparam int unsigned BCD_CNT_W    = $clog2(DISP_W);

endpackage

// ----- hdl/square_wave_frequency_meter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square wave frequency meter
// Measures the high time of a sampled square wave and reports period,
// frequency and their decimal digits once per falling edge.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one sampled pin level per timebase tick in
// s_axis_tdata[0]. After reset the meter ignores a pulse already in progress,
// then counts the high ticks of each pulse. The tick that shows the falling
// edge produces one item on the master stream; all other ticks produce none
// and are taken at one per cycle while the meter is not busy with a result.
// A falling edge starts a serial divide of ticks_per_second by the period
// (one quotient bit per cycle), then two shift-and-add-three conversions
// run side by side. s_axis_tready is low from then on until the result
// is loaded into the output register, so the rate is one tick per cycle
// between edges, and no tick is taken while a result is being computed.
// The output register holds a finished item while the receiver stalls and
// the meter keeps taking ticks; a new result waits for the register to free.
// Reset clears the phase, the high count and the output valid, and sets
// ticks_per_second (APB register at address 0) to 1000000.
// ----------------------------------------------------------------------------
module square_wave_frequency_meter
  import sqm_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // APB configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready,
  // Sample stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [0] pin_level, rest zero
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [16:0] period_ticks, [35:17] freq_hz, [39:36] period_digit4,
  // [43:40] period_digit3, [47:44] period_digit2, [51:48] period_digit1,
  // [55:52] period_digit0, [59:56] freq_digit4, [63:60] freq_digit3,
  // [67:64] freq_digit2, [71:68] freq_digit1, [75:72] freq_digit0, rest zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned PER_W = COUNT_WIDTH + 1;
  localparam int unsigned EXT_W = (PER_W > PERIOD_W) ? PER_W : PERIOD_W;

  typedef enum logic [1:0] {
    PH_WAIT_LOW,
    PH_WAIT_HIGH,
    PH_COUNT
  } phase_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_DIV,
    SEQ_BCD,
    SEQ_OUT
  } seq_e;

  phase_e                 phase_q;
  logic [COUNT_WIDTH-1:0] high_q;
  seq_e                   seq_q;
  logic [TPS_W-1:0]       tps_q;
  logic [PER_W-1:0]       period_q;
  logic [FREQ_W-1:0]      freq_q;
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic                   in_acc;
  logic                   pin;
  logic                   fall;
  logic [PER_W-1:0]       period_now;
  logic                   cfg_wr;
  logic                   div_done;
  logic [TPS_W-1:0]       quotient;
  logic [TPS_W-1:0]       freq_val;
  logic [DISP_W-1:0]      freq_disp;
  logic [EXT_W-1:0]       period_ext;
  logic [DISP_W-1:0]      period_disp;
  logic [PERIOD_W-1:0]    period_field;
  logic                   per_bcd_done;
  logic                   frq_bcd_done;
  logic [BCD_W-1:0]       per_bcd;
  logic [BCD_W-1:0]       frq_bcd;
  logic                   out_free;

  assign pin           = s_axis_tdata[0];
  assign s_axis_tready = (seq_q == SEQ_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign fall          = in_acc && (phase_q == PH_COUNT) && !pin;
  assign period_now    = {high_q, 1'b0};

  // Configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TPS);
  assign prdata = (paddr[2] == REG_TPS) ? APB_DATA_W'(tps_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TPS_W'(TPS_RESET);
    end else if (cfg_wr) begin
      tps_q <= pwdata[TPS_W-1:0];
    end
  end

  // Edge tracking and high-time counter; the count saturates on long pulses.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT_LOW;
      high_q  <= '0;
    end else if (in_acc) begin
      case (phase_q)
        PH_WAIT_HIGH: begin
          if (pin) begin
            high_q  <= COUNT_WIDTH'(1);
            phase_q <= PH_COUNT;
          end
        end
        PH_COUNT: begin
          if (pin) begin
            if (high_q != '1) begin
              high_q <= high_q + 1'b1;
            end
          end else begin
            high_q  <= '0;
            phase_q <= PH_WAIT_HIGH;
          end
        end
        default: begin
          if (!pin) begin
            phase_q <= PH_WAIT_HIGH;
          end
        end
      endcase
    end
  end

  sqm_div #(
    .DIVISOR_W (PER_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (fall),
    .dividend_i (tps_q),
    .divisor_i  (period_now),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign freq_val     = (period_q == '0) ? '0 : quotient;
  assign freq_disp    = (freq_val > TPS_W'(DISPLAY_MAX)) ? DISP_W'(DISPLAY_MAX) :
                        freq_val[DISP_W-1:0];
  assign period_ext   = EXT_W'(period_q);
  assign period_disp  = (period_ext > EXT_W'(DISPLAY_MAX)) ? DISP_W'(DISPLAY_MAX) :
                        period_ext[DISP_W-1:0];
  assign period_field = (period_ext > EXT_W'(PERIOD_MAX)) ? PERIOD_W'(PERIOD_MAX) :
                        period_ext[PERIOD_W-1:0];

  sqm_bcd u_per_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_done),
    .value_i (period_disp),
    .done_o  (per_bcd_done),
    .bcd_o   (per_bcd)
  );

  sqm_bcd u_frq_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_done),
    .value_i (freq_disp),
    .done_o  (frq_bcd_done),
    .bcd_o   (frq_bcd)
  );

  // Digits leave most significant first, so the BCD words are reversed.
  always_comb begin
    out_data_d = '0;
    out_data_d[PERIOD_W-1:0]          = period_field;
    out_data_d[PERIOD_W +: FREQ_W]    = freq_q;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      out_data_d[PERIOD_W + FREQ_W + i*DIGIT_W +: DIGIT_W] =
        per_bcd[(NUM_DIGITS-1-i)*DIGIT_W +: DIGIT_W];
      out_data_d[PERIOD_W + FREQ_W + BCD_W + i*DIGIT_W +: DIGIT_W] =
        frq_bcd[(NUM_DIGITS-1-i)*DIGIT_W +: DIGIT_W];
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SEQ_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (seq_q == SEQ_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (seq_q)
        SEQ_IDLE: begin
          if (fall) begin
            seq_q <= SEQ_DIV;
          end
        end
        SEQ_DIV: begin
          if (div_done) begin
            seq_q <= SEQ_BCD;
          end
        end
        SEQ_BCD: begin
          if (per_bcd_done && frq_bcd_done) begin
            seq_q <= SEQ_OUT;
          end
        end
        SEQ_OUT: begin
          if (out_free) begin
            seq_q <= SEQ_IDLE;
          end
        end
        default: begin
          seq_q <= SEQ_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (fall) begin
      period_q <= period_now;
    end
    if (div_done) begin
      freq_q <= freq_val[FREQ_W-1:0];
    end
    if (seq_q == SEQ_OUT && out_free) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- hdl/sqm_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial restoring divider
// Produces one quotient bit per cycle of the ticks-per-second value divided
// by the measured period; done_o marks the result once all TPS_W bits are in.
// ----------------------------------------------------------------------------
module sqm_div
  import sqm_pkg::*;
#(
  parameter int unsigned DIVISOR_W = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [TPS_W-1:0]     dividend_i,
  input  logic [DIVISOR_W-1:0] divisor_i,
  output logic                 done_o,
  output logic [TPS_W-1:0]     quotient_o
);

  localparam int unsigned TRIAL_W = DIVISOR_W + 1;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIVISOR_W-1:0] dvs_q, dvs_d;
  logic [TPS_W-1:0]     quo_q, quo_d;
  logic [TRIAL_W-1:0]   trial;
  logic [TRIAL_W-1:0]   diff;
  logic                 fits;

  // The remainder stays below the divisor, so the trial value is below twice
  // the divisor and the difference always fits back into the remainder.
  always_comb begin
    trial  = {rem_q, quo_q[TPS_W-1]};
    diff   = trial - {1'b0, dvs_q};
    fits   = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_d = {quo_q[TPS_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(TPS_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- hdl/sqm_bcd.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial binary to BCD converter
// Shift-and-add-three conversion, one input bit per cycle, five digits out.
// ----------------------------------------------------------------------------
module sqm_bcd
  import sqm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DISP_W-1:0] value_i,
  output logic              done_o,
  output logic [BCD_W-1:0]  bcd_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [BCD_CNT_W-1:0] cnt_q, cnt_d;
  logic [DISP_W-1:0]    bin_q, bin_d;
  logic [BCD_W-1:0]     bcd_q, bcd_d;
  logic [BCD_W-1:0]     adj;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i*DIGIT_W +: DIGIT_W] = (bcd_q[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) ?
                                  bcd_q[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3) :
                                  bcd_q[i*DIGIT_W +: DIGIT_W];
    end
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      bin_d  = value_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      bcd_d = {adj[BCD_W-2:0], bin_q[DISP_W-1]};
      bin_d = {bin_q[DISP_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == BCD_CNT_W'(DISP_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

// ----- hdl/sqm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square wave frequency meter checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module sqm_checker
  import sqm_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic digits_ok;

  always_comb begin
    digits_ok = 1'b1;
    for (int i = 0; i < 2 * NUM_DIGITS; i++) begin
      if (m_axis_tdata[PERIOD_W + FREQ_W + i*DIGIT_W +: DIGIT_W] > DIGIT_W'(9)) begin
        digits_ok = 1'b0;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> digits_ok)
    else $error("result digit above nine");

  a_period_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] == 1'b0) ||
                      (m_axis_tdata[PERIOD_W-1:0] == PERIOD_W'(PERIOD_MAX)))
    else $error("period neither even nor saturated");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without a computation");

endmodule

bind square_wave_frequency_meter sqm_checker u_sqm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
